FILE: src/swrs_pkg.sv
// Shared constants, command and status types, and the quarter-wave sine table.
package swrs_pkg;

  // Geometry of the row store and the shift range.
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_SHIFT    = 48;
  localparam int SINE_ENTRIES = 1024;

  localparam int LINE_AW    = $clog2(MAX_WIDTH);
  localparam int COL_W      = LINE_AW + 1;
  localparam int POS_W      = COL_W + 1;
  localparam int SINE_AW    = $clog2(SINE_ENTRIES);
  localparam int QUARTER    = SINE_ENTRIES / 4;
  localparam int QUARTER_AW = SINE_AW - 2;
  localparam int SINE_MAG_W = 15;
  localparam int PROD_W     = 2 * SINE_MAG_W;
  localparam int OFS_W      = $clog2(MAX_SHIFT + 1) + 1;

  // Field and register widths.
  localparam int PIX_W       = 32;
  localparam int AMP_W       = 6;
  localparam int STEP_W      = 16;
  localparam int PHASE_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [PIX_W-1:0]  WHITE_PIXEL       = '1;
  localparam logic [AMP_W-1:0]  AMPLITUDE_RESET   = AMP_W'(42);
  localparam logic [STEP_W-1:0] FRAME_STEP_RESET  = STEP_W'(720);
  localparam logic [STEP_W-1:0] ROW_STEP_RESET    = STEP_W'(695);

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_AMPLITUDE  = 2'd0,
    CFG_FRAME_STEP = 2'd1,
    CFG_ROW_STEP   = 2'd2
  } cfg_reg_t;

  // Steps of the per-row offset calculation.
  typedef enum logic [1:0] {
    PREP_FRAME_SINE,
    PREP_ROW_SINE,
    PREP_MULTIPLY,
    PREP_SCALE
  } prep_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     prep_en;
    prep_op_t prep_op;
    logic     stream_en;
    logic     flush_en;
  } swrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic col_zero;
    logic row_end_acc;
    logic flush_done;
  } swrs_sts_t;

  // Sine magnitude at quarter-turn position r (0..16384), Q0.15, rounded.
  // A degree-9 Taylor polynomial in Q30; evaluated only while elaborating.
  function automatic logic [SINE_MAG_W-1:0] quarter_sine(input logic [14:0] r);
    logic [63:0] one_q30;
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    one_q30 = 64'd1 << 30;
    a  = 64'(r) * 64'd102944;
    x2 = (a * a) >> 30;
    t  = one_q30 - x2 / 64'd72;
    t  = one_q30 - ((x2 * t) >> 30) / 64'd42;
    t  = one_q30 - ((x2 * t) >> 30) / 64'd20;
    t  = one_q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (a * t) >> 30;
    v  = (s * 64'd32767 + (one_q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_MAG_W-1:0];
  endfunction

  // First quarter of the table, both ends included, packed one entry after another.
  function automatic logic [(QUARTER+1)*SINE_MAG_W-1:0] sine_quarter_table();
    logic [(QUARTER+1)*SINE_MAG_W-1:0] tbl;
    tbl = '0;
    for (int k = 0; k <= QUARTER; k++) begin
      tbl[k*SINE_MAG_W +: SINE_MAG_W] = quarter_sine(15'(k * (16384 / QUARTER)));
    end
    return tbl;
  endfunction

  localparam logic [(QUARTER+1)*SINE_MAG_W-1:0] SINE_QUARTER = sine_quarter_table();

endpackage

FILE: src/swrs_ctrl.sv
// Controller: sequences the offset setup, the pixel stream and the row flush.
module swrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  swrs_pkg::swrs_sts_t sts,
  output swrs_pkg::swrs_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_FRAME_SINE,
    ST_ROW_SINE,
    ST_MULTIPLY,
    ST_SCALE,
    ST_STREAM,
    ST_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state. A register write before the first pixel of a row restarts the setup.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FRAME_SINE: begin
        state_nxt = cfg_we ? ST_FRAME_SINE : ST_ROW_SINE;
      end
      ST_ROW_SINE: begin
        state_nxt = cfg_we ? ST_FRAME_SINE : ST_MULTIPLY;
      end
      ST_MULTIPLY: begin
        state_nxt = cfg_we ? ST_FRAME_SINE : ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = cfg_we ? ST_FRAME_SINE : ST_STREAM;
      end
      ST_STREAM: begin
        if (sts.row_end_acc) begin
          state_nxt = ST_FLUSH;
        end else if (sts.col_zero && cfg_we) begin
          state_nxt = ST_FRAME_SINE;
        end
      end
      ST_FLUSH: begin
        if (sts.flush_done) begin
          state_nxt = ST_FRAME_SINE;
        end
      end
      default: begin
        state_nxt = ST_FRAME_SINE;
      end
    endcase
  end

  // Command decode.
  always_comb begin
    cmd.prep_en   = 1'b0;
    cmd.prep_op   = swrs_pkg::PREP_FRAME_SINE;
    cmd.stream_en = 1'b0;
    cmd.flush_en  = 1'b0;
    unique case (state_r)
      ST_FRAME_SINE: begin
        cmd.prep_en = 1'b1;
        cmd.prep_op = swrs_pkg::PREP_FRAME_SINE;
      end
      ST_ROW_SINE: begin
        cmd.prep_en = 1'b1;
        cmd.prep_op = swrs_pkg::PREP_ROW_SINE;
      end
      ST_MULTIPLY: begin
        cmd.prep_en = 1'b1;
        cmd.prep_op = swrs_pkg::PREP_MULTIPLY;
      end
      ST_SCALE: begin
        cmd.prep_en = 1'b1;
        cmd.prep_op = swrs_pkg::PREP_SCALE;
      end
      ST_STREAM: begin
        cmd.stream_en = !(sts.col_zero && cfg_we);
      end
      ST_FLUSH: begin
        cmd.flush_en = 1'b1;
      end
      default: begin
        cmd.prep_en = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FRAME_SINE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/swrs_dp.sv
// Datapath: phase tracking, row offset, row store and the two-stage output pipeline.
module swrs_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [swrs_pkg::AMP_W-1:0]           amplitude,
  input  logic [swrs_pkg::STEP_W-1:0]          frame_step,
  input  logic [swrs_pkg::STEP_W-1:0]          row_step,
  input  swrs_pkg::swrs_cmd_t                  cmd,
  output swrs_pkg::swrs_sts_t                  sts,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [swrs_pkg::PIX_W-1:0]           in_pixel,
  input  logic                                 in_row_end,
  input  logic                                 in_frame_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [swrs_pkg::PIX_W-1:0]           out_pixel,
  output logic                                 out_row_end,
  output logic                                 out_frame_end
);

  typedef enum logic [1:0] {
    SEL_MEM,
    SEL_WHITE,
    SEL_FWD
  } sel_t;

  // Frame and row phase state.
  logic [swrs_pkg::STEP_W-1:0]   frame_count_r;
  logic [swrs_pkg::PHASE_W-1:0]  frame_phase_r;
  logic [swrs_pkg::PHASE_W-1:0]  row_phase_r;
  logic [swrs_pkg::STEP_W-1:0]   fc_inc;
  logic [2*swrs_pkg::STEP_W-1:0] fp_prod;
  logic [2*swrs_pkg::STEP_W-1:0] rp_prod;
  logic [swrs_pkg::PHASE_W-1:0]  row_phase_nxt;

  // Offset calculation.
  logic [swrs_pkg::SINE_MAG_W-1:0]            fs_mag_r;
  logic                                       fs_neg_r;
  logic [swrs_pkg::SINE_MAG_W-1:0]            rs_mag_r;
  logic                                       rs_neg_r;
  logic [swrs_pkg::PROD_W-1:0]                mag_prod_r;
  logic signed [swrs_pkg::OFS_W-1:0]          row_offset_r;
  logic [swrs_pkg::PHASE_W-1:0]               prep_phase;
  logic [swrs_pkg::SINE_AW-1:0]               sine_idx;
  logic [1:0]                                 quad;
  logic [swrs_pkg::QUARTER_AW:0]              q_pos;
  logic [swrs_pkg::SINE_MAG_W-1:0]            sine_mag;
  logic [swrs_pkg::AMP_W+swrs_pkg::PROD_W-1:0] scaled;
  logic [swrs_pkg::AMP_W-1:0]                 scale_q;
  logic [swrs_pkg::OFS_W-2:0]                 ofs_mag;
  logic signed [swrs_pkg::OFS_W-1:0]          offset_nxt;

  // Row position and flush.
  logic [swrs_pkg::COL_W-1:0] column_r;
  logic [swrs_pkg::COL_W-1:0] column_nxt;
  logic [swrs_pkg::COL_W-1:0] flush_x_r;
  logic [swrs_pkg::COL_W-1:0] flush_end_r;
  logic                       flush_frame_r;
  logic [swrs_pkg::COL_W-1:0] width_w;
  logic [swrs_pkg::COL_W-1:0] flush_start;
  logic                       flush_last;

  // Source column lookup.
  logic [swrs_pkg::COL_W-1:0]        src_x;
  logic [swrs_pkg::COL_W-1:0]        limit_x;
  logic signed [swrs_pkg::POS_W-1:0] src_pos;
  logic signed [swrs_pkg::POS_W-1:0] src_limit;
  logic                              src_white;
  logic                              src_fwd;
  sel_t                              sel_nxt;

  // Handshake and pipeline.
  logic b_free;
  logic a_free;
  logic in_acc;
  logic has_room;
  logic row_end_eff;
  logic emit_now;
  logic flush_step;
  logic a_load;

  logic [swrs_pkg::PIX_W-1:0] line_mem [swrs_pkg::MAX_WIDTH];
  logic [swrs_pkg::PIX_W-1:0] rd_data_r;
  logic                       a_valid_r;
  sel_t                       a_sel_r;
  logic [swrs_pkg::PIX_W-1:0] a_pix_r;
  logic                       a_row_end_r;
  logic                       a_frame_end_r;
  logic                       out_valid_r;
  logic [swrs_pkg::PIX_W-1:0] out_pixel_r;
  logic                       out_row_end_r;
  logic                       out_frame_end_r;

  // Transfer control: stage A feeds the output register.
  assign b_free      = !out_valid_r || !out_stall;
  assign a_free      = !a_valid_r || b_free;
  assign in_stall    = !(cmd.stream_en && a_free);
  assign in_acc      = in_valid && !in_stall;
  assign flush_step  = cmd.flush_en && a_free;
  assign has_room    = column_r < swrs_pkg::COL_W'(swrs_pkg::MAX_WIDTH);
  assign row_end_eff = in_row_end || in_frame_end;
  assign emit_now    = in_acc && has_room && (column_r >= swrs_pkg::COL_W'(swrs_pkg::MAX_SHIFT));
  assign a_load      = emit_now || flush_step;
  assign flush_last  = flush_x_r == flush_end_r;

  assign sts.col_zero    = column_r == '0;
  assign sts.row_end_acc = in_acc && row_end_eff;
  assign sts.flush_done  = flush_step && flush_last;

  // Sine lookup through the quarter-wave table.
  assign prep_phase = (cmd.prep_op == swrs_pkg::PREP_FRAME_SINE) ? frame_phase_r : row_phase_r;
  assign sine_idx   = prep_phase[swrs_pkg::PHASE_W-1 -: swrs_pkg::SINE_AW];
  assign quad       = sine_idx[swrs_pkg::SINE_AW-1 -: 2];
  assign q_pos      = quad[0]
                    ? (swrs_pkg::QUARTER_AW+1)'(swrs_pkg::QUARTER)
                      - {1'b0, sine_idx[swrs_pkg::QUARTER_AW-1:0]}
                    : {1'b0, sine_idx[swrs_pkg::QUARTER_AW-1:0]};
  assign sine_mag   = swrs_pkg::SINE_QUARTER[q_pos*swrs_pkg::SINE_MAG_W +: swrs_pkg::SINE_MAG_W];

  // Scale by amplitude, drop the Q30 fraction, saturate and apply the sign.
  assign scaled  = amplitude * mag_prod_r;
  assign scale_q = scaled[swrs_pkg::AMP_W+swrs_pkg::PROD_W-1 -: swrs_pkg::AMP_W];
  assign ofs_mag = (scale_q > swrs_pkg::AMP_W'(swrs_pkg::MAX_SHIFT))
                 ? (swrs_pkg::OFS_W-1)'(swrs_pkg::MAX_SHIFT)
                 : (swrs_pkg::OFS_W-1)'(scale_q);
  assign offset_nxt = (fs_neg_r ^ rs_neg_r) ? -$signed({1'b0, ofs_mag}) : $signed({1'b0, ofs_mag});

  // Phase advance at the end of a row, restarted from the frame count at frame end.
  assign fc_inc  = frame_count_r + 1'b1;
  assign fp_prod = fc_inc * frame_step;
  assign rp_prod = fc_inc * row_step;
  assign row_phase_nxt = in_frame_end ? rp_prod[swrs_pkg::PHASE_W-1:0] : row_phase_r + row_step;

  // Row length and first flushed column.
  assign width_w     = has_room ? column_r + 1'b1 : column_r;
  assign flush_start = (width_w > swrs_pkg::COL_W'(swrs_pkg::MAX_SHIFT))
                     ? width_w - swrs_pkg::COL_W'(swrs_pkg::MAX_SHIFT) : '0;
  assign column_nxt  = row_end_eff ? '0 : (has_room ? column_r + 1'b1 : column_r);

  // Source column for the output being produced, and its bound in the row.
  assign src_x     = cmd.flush_en ? flush_x_r : column_r - swrs_pkg::COL_W'(swrs_pkg::MAX_SHIFT);
  assign limit_x   = cmd.flush_en ? flush_end_r : column_r;
  assign src_pos   = $signed({1'b0, src_x}) + swrs_pkg::POS_W'(row_offset_r);
  assign src_limit = $signed({1'b0, limit_x});
  assign src_white = (src_pos < 0) || (src_pos > src_limit);
  assign src_fwd   = !cmd.flush_en && (src_pos == src_limit);
  assign sel_nxt   = src_white ? SEL_WHITE : (src_fwd ? SEL_FWD : SEL_MEM);

  // Row store: write the incoming pixel, read the source column.
  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      line_mem[column_r[swrs_pkg::LINE_AW-1:0]] <= in_pixel;
    end
    if (a_load && sel_nxt == SEL_MEM) begin
      rd_data_r <= line_mem[src_pos[swrs_pkg::LINE_AW-1:0]];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      frame_phase_r <= '0;
      row_phase_r   <= '0;
      row_offset_r  <= '0;
      column_r      <= '0;
      flush_x_r     <= '0;
      flush_end_r   <= '0;
      flush_frame_r <= 1'b0;
      a_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.prep_en && cmd.prep_op == swrs_pkg::PREP_SCALE) begin
        row_offset_r <= offset_nxt;
      end
      if (in_acc) begin
        column_r <= column_nxt;
      end
      if (in_acc && row_end_eff) begin
        row_phase_r   <= row_phase_nxt;
        flush_x_r     <= flush_start;
        flush_end_r   <= width_w - 1'b1;
        flush_frame_r <= in_frame_end;
        if (in_frame_end) begin
          frame_count_r <= fc_inc;
          frame_phase_r <= fp_prod[swrs_pkg::PHASE_W-1:0];
        end
      end else if (flush_step) begin
        flush_x_r <= flush_x_r + 1'b1;
      end
      if (a_load) begin
        a_valid_r <= 1'b1;
      end else if (b_free) begin
        a_valid_r <= 1'b0;
      end
      if (b_free) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  // Offset setup and pipeline payload.
  always_ff @(posedge clk) begin
    if (cmd.prep_en && cmd.prep_op == swrs_pkg::PREP_FRAME_SINE) begin
      fs_mag_r <= sine_mag;
      fs_neg_r <= quad[1];
    end
    if (cmd.prep_en && cmd.prep_op == swrs_pkg::PREP_ROW_SINE) begin
      rs_mag_r <= sine_mag;
      rs_neg_r <= quad[1];
    end
    if (cmd.prep_en && cmd.prep_op == swrs_pkg::PREP_MULTIPLY) begin
      mag_prod_r <= fs_mag_r * rs_mag_r;
    end
    if (a_load) begin
      a_sel_r       <= sel_nxt;
      a_pix_r       <= in_pixel;
      a_row_end_r   <= flush_step && flush_last;
      a_frame_end_r <= flush_step && flush_last && flush_frame_r;
    end
    if (b_free && a_valid_r) begin
      case (a_sel_r)
        SEL_WHITE: out_pixel_r <= swrs_pkg::WHITE_PIXEL;
        SEL_FWD:   out_pixel_r <= a_pix_r;
        default:   out_pixel_r <= rd_data_r;
      endcase
      out_row_end_r   <= a_row_end_r;
      out_frame_end_r <= a_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel     = out_pixel_r;
  assign out_row_end   = out_row_end_r;
  assign out_frame_end = out_frame_end_r;

  // The flush pointer never passes the last column of the row.
  a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_en |-> flush_x_r <= flush_end_r)
    else $error("flush pointer beyond row end");

  // No input transfer is taken while a row is being flushed.
  a_no_input_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_en |-> !in_acc)
    else $error("input transfer during flush");

  // The column count stays within the row store.
  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> column_r <= swrs_pkg::COL_W'(swrs_pkg::MAX_WIDTH))
    else $error("column count out of range");

  // A frame end is only ever flagged on the last pixel of a row.
  a_frame_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_end_r) |-> out_row_end_r)
    else $error("frame end without row end");

endmodule

FILE: src/sine_wave_row_shift.sv
// Top level of the sine-wave row shifter: configuration registers, controller and datapath.
//
//   Port group   Direction  Handshake            Payload
//   in_*         input      in_valid / in_stall  in_pixel, in_row_end, in_frame_end
//   out_*        output     out_valid / out_stall out_pixel, out_row_end, out_frame_end
//   cfg_*        input      cfg_we               cfg_index, cfg_data
//
// Within a row one pixel is taken per clock unless the output stalls; column x leaves
// after the transfer of input column x + 48, through a registered read of the row store
// into stage A and then the output register. After the last pixel of a row the tail is
// flushed at one pixel per clock unless the output stalls, min(W, 48) pixels in all; then
// the next row's offset is computed (two table reads, the product and the scaling).
// Reset is synchronous; the row store is not cleared and needs no clearing pass.
// A stalled output holds a two-entry pipeline; input stalls once both entries are full.
module sine_wave_row_shift (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [swrs_pkg::PIX_W-1:0]           in_pixel,
  input  logic                                 in_row_end,
  input  logic                                 in_frame_end,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [swrs_pkg::PIX_W-1:0]           out_pixel,
  output logic                                 out_row_end,
  output logic                                 out_frame_end,
  input  logic                                 cfg_we,
  input  logic [swrs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [swrs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [swrs_pkg::AMP_W-1:0]  amplitude_r;
  logic [swrs_pkg::STEP_W-1:0] frame_step_r;
  logic [swrs_pkg::STEP_W-1:0] row_step_r;
  swrs_pkg::swrs_cmd_t         cmd;
  swrs_pkg::swrs_sts_t         sts;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r  <= swrs_pkg::AMPLITUDE_RESET;
      frame_step_r <= swrs_pkg::FRAME_STEP_RESET;
      row_step_r   <= swrs_pkg::ROW_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swrs_pkg::CFG_AMPLITUDE:  amplitude_r  <= cfg_data[swrs_pkg::AMP_W-1:0];
        swrs_pkg::CFG_FRAME_STEP: frame_step_r <= cfg_data[swrs_pkg::STEP_W-1:0];
        swrs_pkg::CFG_ROW_STEP:   row_step_r   <= cfg_data[swrs_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  swrs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_we (cfg_we),
    .sts    (sts),
    .cmd    (cmd)
  );

  // Pixel datapath.
  swrs_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .amplitude     (amplitude_r),
    .frame_step    (frame_step_r),
    .row_step      (row_step_r),
    .cmd           (cmd),
    .sts           (sts),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel      (in_pixel),
    .in_row_end    (in_row_end),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel     (out_pixel),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

endmodule
